@@ hdl/pmg_pkg.sv @@
package pmg_pkg;

  // register indexes
  localparam logic [2:0] REG_POS0   = 3'd0;
  localparam logic [2:0] REG_POS1   = 3'd1;
  localparam logic [2:0] REG_POS2   = 3'd2;
  localparam logic [2:0] REG_MASS0  = 3'd3;
  localparam logic [2:0] REG_MASS1  = 3'd4;
  localparam logic [2:0] REG_MASS2  = 3'd5;
  localparam logic [2:0] REG_ENABLE = 3'd6;

  localparam int NUM_SLOTS = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SQRT,
    ST_DEN,
    ST_DIVX,
    ST_ACCX,
    ST_DIVY,
    ST_ACCY,
    ST_NEXT,
    ST_FINAL,
    ST_OUT
  } state_t;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SQRT,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [49:0] a;   // sqrt radicand or dividend
    logic [57:0] b;   // divisor, up to d^2 * sqrt(d^2 * 2^16)
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [49:0] res;
  } unit_rsp_t;

endpackage

@@ hdl/point_mass_gravity_velocity_update.sv @@
// channel  direction  handshake              payload
// s_axis   in         s_tvalid / s_tready    s_tdata: body_x, body_y, vx, vy
// m_axis   out        m_tvalid / m_tready    m_tdata: vx, vy; m_tuser: flags
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an enabled attractor runs the square root (25 steps) and a 32-step division
// for each axis between its sequencing states; a disabled slot is skipped in
// the slot check and a coincident one returns to it after setup. an item also
// passes acceptance, the last slot check, the final clip and the output.
// the input is not ready while an item is in work or its result waits.
// rst is synchronous and clears the configuration registers and the sequencer.
module point_mass_gravity_velocity_update #(
  parameter int MAX_ATTRACTORS = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // body_x, body_y, velocity_x_in, velocity_y_in
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // velocity_x_out, velocity_y_out
  output logic [1:0]   m_tuser,   // saturated, zero_distance
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;

  logic [31:0] pos  [MAX_ATTRACTORS];
  logic [15:0] mass [MAX_ATTRACTORS];
  logic [MAX_ATTRACTORS-1:0] en;

  pmg_pkg::state_t state, state_next;
  pmg_pkg::unit_req_t req;
  pmg_pkg::unit_rsp_t rsp;

  logic signed [15:0] bx, by;
  logic signed [31:0] vx0, vy0;
  logic [IW-1:0] idx;
  logic [IW:0] nidx;
  logic signed [16:0] dx, dy;
  logic [15:0] adx, ady;
  logic [32:0] d2;
  logic [57:0] den;
  logic [31:0] mx, my;
  logic signed [35:0] ax, ay;
  logic sat, zero;
  logic [31:0] ox, oy;

  logic signed [16:0] cdx, cdy;
  logic [15:0] cadx, cady;
  logic [32:0] cd2;
  logic coincident;
  logic capx, capy;
  logic cx, cy;
  logic [31:0] fx, fy;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ATTRACTORS; i++) begin
        pos[i]  <= '0;
        mass[i] <= '0;
      end
      en <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < MAX_ATTRACTORS; i++) begin
        if (cfg_index == pmg_pkg::REG_POS0 + 3'(i)) pos[i] <= cfg_data;
        if (cfg_index == pmg_pkg::REG_MASS0 + 3'(i)) mass[i] <= cfg_data[15:0];
      end
      if (cfg_index == pmg_pkg::REG_ENABLE) en <= cfg_data[MAX_ATTRACTORS-1:0];
    end
  end

  // delta and square of the distance for the current attractor
  always_comb begin
    cdx  = 17'(bx) - 17'($signed(pos[idx][31:16]));
    cdy  = 17'(by) - 17'($signed(pos[idx][15:0]));
    cadx = cdx[16] ? 16'(-cdx) : cdx[15:0];
    cady = cdy[16] ? 16'(-cdy) : cdy[15:0];
    cd2  = 33'(cadx) * 33'(cadx) + 33'(cady) * 33'(cady);
    coincident = (cdx == 17'sd0) && (cdy == 17'sd0);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pmg_pkg::ST_IDLE:  if (s_tvalid) state_next = pmg_pkg::ST_NEXT;
      pmg_pkg::ST_SETUP: state_next = coincident ? pmg_pkg::ST_NEXT : pmg_pkg::ST_SQRT;
      pmg_pkg::ST_SQRT:  if (rsp.done) state_next = pmg_pkg::ST_DEN;
      pmg_pkg::ST_DEN:   state_next = pmg_pkg::ST_DIVX;
      pmg_pkg::ST_DIVX:  if (rsp.done) state_next = pmg_pkg::ST_ACCX;
      pmg_pkg::ST_ACCX:  state_next = pmg_pkg::ST_DIVY;
      pmg_pkg::ST_DIVY:  if (rsp.done) state_next = pmg_pkg::ST_ACCY;
      pmg_pkg::ST_ACCY:  state_next = pmg_pkg::ST_NEXT;
      pmg_pkg::ST_NEXT: begin
        // skip disabled attractors
        if (nidx >= (IW+1)'(MAX_ATTRACTORS)) state_next = pmg_pkg::ST_FINAL;
        else if (en[nidx[IW-1:0]]) state_next = pmg_pkg::ST_SETUP;
      end
      pmg_pkg::ST_FINAL: state_next = pmg_pkg::ST_OUT;
      pmg_pkg::ST_OUT:   if (m_tready) state_next = pmg_pkg::ST_IDLE;
      default:           state_next = pmg_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit requests
  always_comb begin
    s_tready  = (state == pmg_pkg::ST_IDLE);
    m_tvalid  = (state == pmg_pkg::ST_OUT);
    req.start = 1'b0;
    req.op    = pmg_pkg::OP_NONE;
    req.a     = '0;
    req.b     = den;
    case (state)
      pmg_pkg::ST_SETUP: begin
        req.start = !coincident;
        req.op    = pmg_pkg::OP_SQRT;
        req.a     = {1'b0, cd2, 16'd0};
      end
      pmg_pkg::ST_DEN: begin
        req.start = 1'b1;
        req.op    = pmg_pkg::OP_DIV;
        req.a     = 50'(mx);
      end
      pmg_pkg::ST_ACCX: begin
        req.start = 1'b1;
        req.op    = pmg_pkg::OP_DIV;
        req.a     = 50'(my);
      end
      default: ;
    endcase
  end

  // term capped at 2^31 and signed against delta
  function automatic logic signed [35:0] term(input logic [49:0] q, input logic cap,
                                             input logic pos_d);
    logic [32:0] m;
    m = (cap || q[49:31] != 0 && q > 50'h80000000) ? 33'h080000000 : q[32:0];
    return pos_d ? -36'(m) : 36'(m);
  endfunction

  assign capx = (mx >= den[31:0]) && (den[57:32] == '0);
  assign capy = (my >= den[31:0]) && (den[57:32] == '0);

  function automatic logic [31:0] clip(input logic signed [35:0] v, output logic c);
    c = 1'b0;
    if (v > 36'sd2147483647) begin c = 1'b1; return 32'h7fffffff; end
    if (v < -36'sd2147483648) begin c = 1'b1; return 32'h80000000; end
    return v[31:0];
  endfunction

  always_comb begin
    fx = clip(36'(vx0) + ax, cx);
    fy = clip(36'(vy0) + ay, cy);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= pmg_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      pmg_pkg::ST_IDLE: if (s_tvalid) begin
        bx   <= s_tdata[15:0];
        by   <= s_tdata[31:16];
        vx0  <= s_tdata[63:32];
        vy0  <= s_tdata[95:64];
        ax   <= '0;
        ay   <= '0;
        sat  <= 1'b0;
        zero <= 1'b0;
        nidx <= '0;
      end
      pmg_pkg::ST_NEXT: if (nidx < (IW+1)'(MAX_ATTRACTORS)) begin
        idx  <= nidx[IW-1:0];
        nidx <= nidx + (IW+1)'(1);
      end
      pmg_pkg::ST_SETUP: begin
        // coincident attractor adds nothing
        if (coincident) zero <= 1'b1;
        dx  <= cdx;
        dy  <= cdy;
        adx <= cadx;
        ady <= cady;
        d2  <= cd2;
      end
      pmg_pkg::ST_SQRT: if (rsp.done) begin
        mx  <= 32'(mass[idx]) * 32'(adx);
        my  <= 32'(mass[idx]) * 32'(ady);
        den <= 58'(d2) * 58'(rsp.res[24:0]);
      end
      pmg_pkg::ST_ACCX: begin
        ax <= ax + term(rsp.res, capx, dx > 17'sd0);
        if (capx || rsp.res > 50'h80000000) sat <= 1'b1;
      end
      pmg_pkg::ST_ACCY: begin
        ay <= ay + term(rsp.res, capy, dy > 17'sd0);
        if (capy || rsp.res > 50'h80000000) sat <= 1'b1;
      end
      pmg_pkg::ST_FINAL: begin
        ox <= fx;
        oy <= fy;
        if (cx || cy) sat <= 1'b1;
      end
      default: ;
    endcase
  end

  assign m_tdata = {oy, ox};
  assign m_tuser = {zero, sat};

  pmg_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("input ready while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state == pmg_pkg::ST_DIVX) |-> !s_tready)
    else $error("ready during division");

endmodule

@@ hdl/pmg_unit.sv @@
// shared iterative unit: bit-pair square root or restoring division,
// one step per cycle
module pmg_unit (
  input  logic               clk,
  input  logic               rst,
  input  pmg_pkg::unit_req_t req,
  output pmg_pkg::unit_rsp_t rsp
);

  logic         busy;
  logic         done;
  pmg_pkg::op_t op;
  logic [5:0]   cnt;
  logic [58:0]  rem;
  logic [49:0]  acc;
  logic [49:0]  src;
  logic [57:0]  dvs;

  logic [58:0] trial;
  logic [58:0] rem_sh;

  // trial value for the current step
  always_comb begin
    if (op == pmg_pkg::OP_SQRT) begin
      rem_sh = {rem[56:0], src[49:48]};
      trial  = {7'd0, acc, 2'b01};
    end else begin
      rem_sh = {rem[57:0], 1'b0};
      trial  = {1'b0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        dvs  <= req.b;
        if (req.op == pmg_pkg::OP_SQRT) begin
          src <= req.a;
          rem <= '0;
          cnt <= 6'd25;
        end else begin
          src <= '0;
          rem <= {9'd0, req.a};
          cnt <= 6'd32;
        end
        acc <= '0;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          acc <= {acc[48:0], 1'b1};
        end else begin
          rem <= rem_sh;
          acc <= {acc[48:0], 1'b0};
        end
        src <= {src[47:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, res: acc};

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("unit still busy after done");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("unit did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> !req.start)
    else $error("unit restarted while busy");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic signed [31:0] vy;
    logic signed [31:0] vx;
    logic signed [15:0] by;
    logic signed [15:0] bx;
  } body_item_t;

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic        sat;
    logic        zero;
  } velocity_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of the attractor registers
  logic [31:0] att_pos [pmg_pkg::NUM_SLOTS];
  logic [15:0] att_mass [pmg_pkg::NUM_SLOTS];
  logic [2:0]  att_enable;

  body_item_t       pending_bodies[$];
  velocity_result_t expected_velocities[$];
  int  mismatches;
  int  results_seen;
  int  sat_seen;
  int  zero_seen;
  bit  calm;
  bit  took;

  point_mass_gravity_velocity_update i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor(num * 2^32 / den) with cap at 2^31
  function automatic logic [63:0] pull_term(input logic [63:0] num, input logic [63:0] den,
                                            inout logic sat);
    logic [127:0] q;
    if (num >= den) begin
      sat = 1'b1;
      return 64'h8000_0000;
    end
    q = ({64'd0, num} << 32) / den;
    if (q > 128'h8000_0000) begin
      sat = 1'b1;
      return 64'h8000_0000;
    end
    return q[63:0];
  endfunction

  function automatic logic signed [31:0] clamp_velocity(input logic signed [63:0] v,
                                                        inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic velocity_result_t predict_velocity(input body_item_t it);
    velocity_result_t r;
    logic signed [63:0] acc_x, acc_y, dx, dy, ta;
    logic [63:0] adx, ady, d2, rt, den;
    logic sat, zero;
    acc_x = 0;
    acc_y = 0;
    sat = 0;
    zero = 0;
    for (int i = 0; i < pmg_pkg::NUM_SLOTS; i++) begin
      if (!att_enable[i]) continue;
      dx = 64'(it.bx) - 64'($signed(att_pos[i][31:16]));
      dy = 64'(it.by) - 64'($signed(att_pos[i][15:0]));
      if (dx == 0 && dy == 0) begin
        zero = 1'b1;
        continue;
      end
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      d2 = adx * adx + ady * ady;
      rt = int_sqrt(d2 << 16);
      den = d2 * rt;
      ta = pull_term(64'(att_mass[i]) * adx, den, sat);
      if (dx > 0) acc_x -= ta; else acc_x += ta;
      ta = pull_term(64'(att_mass[i]) * ady, den, sat);
      if (dy > 0) acc_y -= ta; else acc_y += ta;
    end
    r.vx = clamp_velocity(64'(it.vx) + acc_x, sat);
    r.vy = clamp_velocity(64'(it.vy) + acc_y, sat);
    r.sat = sat;
    r.zero = zero;
    return r;
  endfunction

  // accepted body transaction: predict and retire it
  always @(posedge clk) begin
    took = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      expected_velocities.insert(expected_velocities.size(),
                                 predict_velocity(body_item_t'(s_tdata)));
      void'(pending_bodies.pop_front());
      took = 1'b1;
    end
  end

  // body transaction driver, an offered transaction is held until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || took) begin
        if (pending_bodies.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_bodies[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || $urandom_range(99) >= 10;
    end
  end

  // result monitor
  always @(posedge clk) begin
    velocity_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_velocities.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %b", m_tdata, m_tuser);
      end else begin
        e = expected_velocities.pop_front();
        if (m_tuser[0]) sat_seen++;
        if (m_tuser[1]) zero_seen++;
        if (m_tdata[31:0] !== e.vx || m_tdata[63:32] !== e.vy ||
            m_tuser[0] !== e.sat || m_tuser[1] !== e.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp vx %h vy %h sat %b zero %b, got vx %h vy %h sat %b zero %b",
                     e.vx, e.vy, e.sat, e.zero, m_tdata[31:0], m_tdata[63:32],
                     m_tuser[0], m_tuser[1]);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pmg_pkg::REG_POS0, pmg_pkg::REG_POS1, pmg_pkg::REG_POS2: att_pos[idx] = val;
      pmg_pkg::REG_MASS0, pmg_pkg::REG_MASS1, pmg_pkg::REG_MASS2:
        att_mass[idx - pmg_pkg::REG_MASS0] = val[15:0];
      pmg_pkg::REG_ENABLE: att_enable = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_bodies.size() != 0 || expected_velocities.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] near_coord(input logic [15:0] c);
    return c + 16'($urandom_range(0, 64)) - 16'd32;
  endfunction

  task automatic push_body(input logic [15:0] x, input logic [15:0] y,
                           input logic [31:0] vx, input logic [31:0] vy);
    body_item_t b;
    b.bx = x;
    b.by = y;
    b.vx = vx;
    b.vy = vy;
    pending_bodies.insert(pending_bodies.size(), b);
  endtask

  // random setting of all attractor registers
  task automatic random_setting(input int flavour);
    for (int i = 0; i < pmg_pkg::NUM_SLOTS; i++) begin
      write_reg(pmg_pkg::REG_POS0 + 3'(i), $urandom);
      case (flavour)
        0: write_reg(pmg_pkg::REG_MASS0 + 3'(i), 32'hffff);
        1: write_reg(pmg_pkg::REG_MASS0 + 3'(i), 32'h0000);
        default: write_reg(pmg_pkg::REG_MASS0 + 3'(i),
                           $urandom_range(0, 65535) >> $urandom_range(0, 15));
      endcase
    end
    write_reg(pmg_pkg::REG_ENABLE, flavour == 0 ? 32'h7 : $urandom);
  endtask

  // stimulus
  initial begin
    logic [15:0] px, py;
    int k;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    sat_seen = 0;
    zero_seen = 0;
    calm = 0;
    foreach (att_pos[i]) begin
      att_pos[i] = '0;
      att_mass[i] = '0;
    end
    att_enable = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: nothing enabled, velocity passes through
    push_body(16'h8000, 16'h7fff, 32'h8000_0000, 32'h7fff_ffff);
    push_body(16'h0000, 16'h0000, 32'h0, 32'hffff_ffff);
    drain_results();

    // directed: strong attractors, coincident body, term cap, sum clip
    write_reg(pmg_pkg::REG_POS0, 32'h0010_0020);
    write_reg(pmg_pkg::REG_POS1, 32'h8000_7fff);
    write_reg(pmg_pkg::REG_POS2, 32'h7fff_8000);
    write_reg(pmg_pkg::REG_MASS0, 32'hffff);
    write_reg(pmg_pkg::REG_MASS1, 32'h0001);
    write_reg(pmg_pkg::REG_MASS2, 32'h0000);
    write_reg(pmg_pkg::REG_ENABLE, 32'h7);
    push_body(16'h0010, 16'h0020, 32'h1234, 32'h5678);
    push_body(16'h0011, 16'h0020, 32'h0, 32'h0);
    push_body(16'h0010, 16'h0021, 32'h7fff_ffff, 32'h8000_0000);
    push_body(16'h000f, 16'h001f, 32'h8000_0000, 32'h7fff_ffff);
    push_body(16'h8000, 16'h7fff, 32'h0, 32'h0);
    push_body(16'h7fff, 16'h8000, 32'h0, 32'h0);
    push_body(16'h7fff, 16'h7fff, 32'hffff_ffff, 32'h1);
    push_body(16'h8000, 16'h8000, 32'h1, 32'hffff_ffff);
    push_body(16'h0100, 16'h0100, 32'h0001_0000, 32'hffff_0000);
    drain_results();
    write_reg(pmg_pkg::REG_ENABLE, 32'h2);
    push_body(16'h8000, 16'h7fff, 32'h5, 32'h5);
    push_body(16'h8001, 16'h7fff, 32'h5, 32'h5);
    push_body(16'h0000, 16'h0000, 32'h5, 32'h5);
    drain_results();
    write_reg(pmg_pkg::REG_ENABLE, 32'h0);
    push_body(16'h1234, 16'h4321, 32'hdead_beef, 32'h0bad_f00d);
    drain_results();

    // random phases; bodies mostly near attractors for strong terms
    for (int ph = 0; ph < 12; ph++) begin
      random_setting(ph % 4);
      calm = (ph == 5);
      for (int n = 0; n < 95; n++) begin
        k = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
          0: begin
            px = $urandom;
            py = $urandom;
          end
          1: begin
            px = att_pos[k][31:16];
            py = att_pos[k][15:0];
          end
          default: begin
            px = near_coord(att_pos[k][31:16]);
            py = near_coord(att_pos[k][15:0]);
          end
        endcase
        push_body(px, py,
                  $urandom_range(0, 3) == 0 ? {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)}
                                            : $urandom,
                  $urandom);
        // hold off once until all results are in
        if (ph == 2 && n == 40) begin
          while (pending_bodies.size() != 0 || expected_velocities.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end
    calm = 0;

    $display("covered %0d results, %0d with saturation, %0d with a coincident attractor",
             results_seen, sat_seen, zero_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ point_mass_gravity_velocity_update.f @@
hdl/pmg_pkg.sv
hdl/pmg_unit.sv
hdl/point_mass_gravity_velocity_update.sv
tb/sv/tb_top.sv
